// ===== src/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// types, codes and widths shared by the recency history blocks
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned LabelW = 32;
  localparam int unsigned VisitW = 16;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CfgW   = 6;
  localparam logic [CfgW-1:0] CapReset = 6'd20;

  typedef enum logic [1:0] {
    FUNC_VISIT   = 2'd0,
    FUNC_BACK    = 2'd1,
    FUNC_FORWARD = 2'd2,
    FUNC_JUMP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_REVISITED  = 3'd1,
    ST_MOVED      = 3'd2,
    ST_NO_CURRENT = 3'd3,
    ST_AT_END     = 3'd4,
    ST_BAD_POS    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE_NEW,
    S_OUT_RD,
    S_OUT_CAP
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [KeyW-1:0]   entry_key;
    logic [LabelW-1:0] entry_label;
    logic [PosW-1:0]   jump_position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
    logic [KeyW-1:0]   current_key;
    logic [LabelW-1:0] current_label;
    logic [VisitW-1:0] current_visits;
    logic [PosW-1:0]   current_position;
    logic [PosW-1:0]   entry_count;
  } out_word_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [LabelW-1:0] label;
    logic [VisitW-1:0] visits;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic nav;
    logic rd_scan;
    logic cmp;
    logic rd_shift;
    logic wr_shift;
    logic wr_new;
    logic rd_out;
    logic cap_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_visit;
    logic empty;
    logic match;
    logic idx_last;
    logic full;
    logic cnt_gt1;
    logic shift_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/rhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhc_ctrl
// sequencer for navigation, scan, shift, append and result capture
// ----------------------------------------------------------------------------
module rhc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rhc_pkg::dp_stat_t stat_i,
  output rhc_pkg::ctrl_cmd_t cmd_o
);
  import rhc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!stat_i.is_visit) state_d = S_OUT_RD;
        else if (stat_i.empty) state_d = S_WRITE_NEW;
        else state_d = S_SCAN_RD;
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (stat_i.match) begin
          state_d = stat_i.idx_last ? S_WRITE_NEW : S_SHIFT_RD;
        end else if (stat_i.idx_last) begin
          state_d = (stat_i.full && stat_i.cnt_gt1) ? S_SHIFT_RD : S_WRITE_NEW;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = stat_i.shift_last ? S_WRITE_NEW : S_SHIFT_RD;
      S_WRITE_NEW: state_d = S_OUT_RD;
      S_OUT_RD: state_d = S_OUT_CAP;
      S_OUT_CAP: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DISPATCH:  cmd_o.nav      = !stat_i.is_visit;
      S_SCAN_RD:   cmd_o.rd_scan  = 1'b1;
      S_SCAN_CMP:  cmd_o.cmp      = 1'b1;
      S_SHIFT_RD:  cmd_o.rd_shift = 1'b1;
      S_SHIFT_WR:  cmd_o.wr_shift = 1'b1;
      S_WRITE_NEW: cmd_o.wr_new   = 1'b1;
      S_OUT_RD:    cmd_o.rd_out   = 1'b1;
      S_OUT_CAP:   cmd_o.cap_out  = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== src/rhc_dpath.sv =====
// ----------------------------------------------------------------------------
// rhc_dpath
// entry memory, count, cursor and result register
// ----------------------------------------------------------------------------
module rhc_dpath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rhc_pkg::in_word_t         in_word_i,
  input  logic                      cfg_valid_i,
  input  logic [rhc_pkg::CfgW-1:0]  cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rhc_pkg::out_word_t        out_word_o,
  input  rhc_pkg::ctrl_cmd_t        cmd_i,
  output rhc_pkg::dp_stat_t         stat_o
);
  import rhc_pkg::*;

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CfgW) ? CW : CfgW;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  in_word_t          in_q;
  logic [CfgW-1:0]   cap_cfg_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              hit_q, evict_q;
  logic [KeyW-1:0]   evkey_q;
  entry_t            saved_q;
  logic [2:0]        status_q, status_d;
  logic              out_valid_q;
  out_word_t         out_q;

  logic [CMPW-1:0]   cap;
  logic [CMPW-1:0]   cnt_x, cur_x, pos_x;
  logic [CW-1:0]     cnt_m1, idx_p1_c;
  logic [IW-1:0]     raddr, waddr;
  logic              we;
  logic              re;
  entry_t            wdata;
  logic              removed;
  logic [VisitW-1:0] inc_visits;

  // capacity: zero acts as one, clipped to depth
  always_comb begin
    cap = CMPW'(cap_cfg_q);
    if (cap == '0) cap = CMPW'(1);
    if (cap > CMPW'(DEPTH)) cap = CMPW'(DEPTH);
  end

  assign cnt_x    = CMPW'(count_q);
  assign cur_x    = CMPW'(cursor_q);
  assign pos_x    = CMPW'(in_q.jump_position);
  assign cnt_m1   = count_q - CW'(1);
  assign idx_p1_c = CW'(idx_q) + CW'(1);
  assign removed  = hit_q | evict_q;
  assign inc_visits = (saved_q.visits == '1) ? saved_q.visits : saved_q.visits + VisitW'(1);

  assign stat_o.is_visit   = (in_q.func == FUNC_VISIT);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.match      = (rdata_q.key == in_q.entry_key);
  assign stat_o.idx_last   = (CW'(idx_q) == cnt_m1);
  assign stat_o.full       = (cnt_x >= cap);
  assign stat_o.cnt_gt1    = (count_q > CW'(1));
  assign stat_o.shift_last = (idx_p1_c == cnt_m1);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  // read address
  always_comb begin
    priority case (1'b1)
      cmd_i.rd_shift: raddr = idx_p1_c[IW-1:0];
      cmd_i.rd_out:   raddr = cnt_x == '0 ? '0 : IW'(cursor_q - CW'(1));
      default:        raddr = idx_q;
    endcase
  end

  // read data is held between reads so a stalled capture keeps it
  assign re = cmd_i.rd_scan | cmd_i.rd_shift | cmd_i.rd_out;

  // write port
  always_comb begin
    we    = cmd_i.wr_shift | cmd_i.wr_new;
    waddr = idx_q;
    wdata = rdata_q;
    if (cmd_i.wr_new) begin
      waddr     = removed ? IW'(cnt_m1) : IW'(count_q);
      wdata.key = in_q.entry_key;
      if (hit_q) begin
        wdata.label  = saved_q.label;
        wdata.visits = inc_visits;
      end else begin
        wdata.label  = in_q.entry_label;
        wdata.visits = VisitW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // index, count, cursor, status
  always_comb begin
    idx_d    = idx_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    status_d = status_q;
    if (cmd_i.load_in) idx_d = '0;
    if (cmd_i.cmp && !stat_o.match) begin
      if (stat_o.idx_last) idx_d = '0;
      else idx_d = idx_q + IW'(1);
    end
    if (cmd_i.wr_shift) idx_d = idx_q + IW'(1);
    if (cmd_i.wr_new) begin
      count_d  = removed ? count_q : count_q + CW'(1);
      cursor_d = count_d;
      status_d = hit_q ? ST_REVISITED : ST_ADDED;
    end
    if (cmd_i.nav) begin
      unique case (in_q.func)
        FUNC_BACK: begin
          priority if (cursor_q == '0) status_d = ST_NO_CURRENT;
          else if (cursor_q <= CW'(1)) status_d = ST_AT_END;
          else begin
            cursor_d = cursor_q - CW'(1);
            status_d = ST_MOVED;
          end
        end
        FUNC_FORWARD: begin
          priority if (cursor_q == '0) status_d = ST_NO_CURRENT;
          else if (cursor_q >= count_q) status_d = ST_AT_END;
          else begin
            cursor_d = cursor_q + CW'(1);
            status_d = ST_MOVED;
          end
        end
        FUNC_JUMP: begin
          if (pos_x == '0 || pos_x > cnt_x) status_d = ST_BAD_POS;
          else begin
            cursor_d = CW'(pos_x);
            status_d = ST_MOVED;
          end
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      evict_q     <= 1'b0;
      cap_cfg_q   <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      idx_q    <= idx_d;
      if (cfg_valid_i) cap_cfg_q <= cfg_data_i;
      if (cmd_i.load_in) begin
        hit_q   <= 1'b0;
        evict_q <= 1'b0;
      end
      if (cmd_i.cmp && stat_o.match) hit_q <= 1'b1;
      if (cmd_i.cmp && !stat_o.match && stat_o.idx_last && stat_o.full) evict_q <= 1'b1;
      if (cmd_i.cap_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_word_i;
    status_q <= status_d;
    if (cmd_i.cmp && idx_q == '0) evkey_q <= rdata_q.key;
    if (cmd_i.cmp && stat_o.match) saved_q <= rdata_q;
    if (cmd_i.cap_out) begin
      out_q.status      <= status_q;
      out_q.evicted     <= evict_q;
      out_q.evicted_key <= evict_q ? evkey_q : '0;
      out_q.entry_count <= PosW'(count_q);
      if (cursor_q == '0) begin
        out_q.current_key      <= '0;
        out_q.current_label    <= '0;
        out_q.current_visits   <= '0;
        out_q.current_position <= '0;
      end else begin
        out_q.current_key      <= rdata_q.key;
        out_q.current_label    <= rdata_q.label;
        out_q.current_visits   <= rdata_q.visits;
        out_q.current_position <= PosW'(cursor_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== src/recency_history_with_cursor.sv =====
// ----------------------------------------------------------------------------
// recency_history_with_cursor
// recency list of visited keys with a navigation cursor
// ----------------------------------------------------------------------------
// Keeps up to DEPTH entries (key, label, visit count) ordered oldest to
// newest in a single-port-write, registered-read memory, plus a cursor. One
// word in gives one word out. Back, forward and jump go from dispatch to
// the output read and capture. A visit reads and compares the held entries
// one at a time, then on a hit (or an eviction) closes the gap one entry at
// a time, reading then writing each, then appends. The entry memory's one
// read port makes the scan and the shift sequential. A finished word waits
// in the output register while the next word is taken.
// The capacity register may be written at any time the block is idle.
module recency_history_with_cursor #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rhc_pkg::in_word_t        in_word_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rhc_pkg::out_word_t       out_word_o,
  // capacity register write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rhc_pkg::CfgW-1:0] cfg_data_i
);
  import rhc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // capacity register always takes a write
  assign cfg_ready_o = 1'b1;

  // sequencer
  rhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  rhc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== src/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker
// port-level checks on the result words
// ----------------------------------------------------------------------------
module rhc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rhc_pkg::out_word_t out_word_o
);
  import rhc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_no_current_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.current_position == '0 |->
      out_word_o.current_key == '0 && out_word_o.current_visits == '0)
    else $error("empty cursor with non-zero entry");

  a_visit_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_ADDED || out_word_o.status == ST_REVISITED) |->
      out_word_o.current_position == out_word_o.entry_count &&
      out_word_o.current_visits != '0)
    else $error("visited entry not newest");

  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.evicted |-> out_word_o.evicted_key == '0)
    else $error("evicted key without eviction");

  a_evict_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.evicted |-> out_word_o.status == ST_ADDED)
    else $error("eviction outside an add");

endmodule

bind recency_history_with_cursor rhc_checker u_rhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
